### design/alpe_pkg.sv
`default_nettype none

package alpe_pkg;

    // Chain geometry
    localparam int PIXEL_COUNT    = 8;
    localparam int BITS_PER_PIXEL = 32;
    localparam int PIX_W          = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int BIT_W          = 5;
    localparam logic [PIX_W-1:0] LAST_PIX  = PIX_W'(PIXEL_COUNT - 1);
    localparam logic [BIT_W-1:0] FIRST_BIT = BIT_W'(BITS_PER_PIXEL - 1);

    // Field widths
    localparam int WORD_W     = 32;
    localparam int IDX_W      = 3;
    localparam int LEN_W      = 10;
    localparam int GAP_W      = 16;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 3'd4;

    // Register reset values
    localparam logic [LEN_W-1:0] ONE_HIGH_RST  = LEN_W'(700 / 5);
    localparam logic [LEN_W-1:0] ONE_LOW_RST   = LEN_W'(800 / 5);
    localparam logic [LEN_W-1:0] ZERO_HIGH_RST = LEN_W'(350 / 5);
    localparam logic [LEN_W-1:0] ZERO_LOW_RST  = LEN_W'(600 / 5);
    localparam logic [GAP_W-1:0] GAP_RST       = GAP_W'(60000 / 5);

    // Item kind carried in tuser
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

endpackage

`default_nettype wire

### design/addressable_led_pulse_encoder_core.sv
`default_nettype none

// Pulse encoder for a chain of serial addressable LEDs.
// Input stream (s_axis): one item per tick or pixel write. tuser[0] selects
// the kind: 0 = one tick of the waveform passes, 1 = write tdata[34:3] into
// pixel tdata[2:0] (indexes past the chain are dropped). Each item yields one
// output item (m_axis): tdata[0] is the data line level during that tick,
// tlast marks the last tick of a frame's trailing gap. A write item reports
// the current level and never tlast.
// Config channel: i_cfg_index selects a timing register, i_cfg_data holds
// the value; ready whenever out of reset. Write it only while the stream is idle.
// Input items are registered as output items; one item per cycle is sustained
// while m_axis_tready stays high. The pixel store sits in a one-port-read RAM
// prefetched at the next pixel to send, so a pixel load never waits on the read.
// A stall on m_axis fills a one-item skid stage, then s_axis_tready drops.
// Reset (sync, active low) empties both output stages, holds both ready
// lines low, restores the timing registers, clears the store via per-entry
// valid bits and restarts the frame at its leading gap.
module addressable_led_pulse_encoder_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [alpe_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // pixel_index, pixel_value
    input  wire logic [0:0]                          s_axis_tuser,  // action
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic      [alpe_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // data_pin
    output logic                                     m_axis_tlast,  // frame_done
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [alpe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [alpe_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2,
        PH_TRAIL = 2'd3
    } t_phase;

    // Timing registers
    logic [alpe_pkg::LEN_W-1:0] r_one_high, r_one_low, r_zero_high, r_zero_low;
    logic [alpe_pkg::GAP_W-1:0] r_gap;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_high  <= alpe_pkg::ONE_HIGH_RST;
            r_one_low   <= alpe_pkg::ONE_LOW_RST;
            r_zero_high <= alpe_pkg::ZERO_HIGH_RST;
            r_zero_low  <= alpe_pkg::ZERO_LOW_RST;
            r_gap       <= alpe_pkg::GAP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                alpe_pkg::CFG_ONE_HIGH:  r_one_high  <= i_cfg_data[alpe_pkg::LEN_W-1:0];
                alpe_pkg::CFG_ONE_LOW:   r_one_low   <= i_cfg_data[alpe_pkg::LEN_W-1:0];
                alpe_pkg::CFG_ZERO_HIGH: r_zero_high <= i_cfg_data[alpe_pkg::LEN_W-1:0];
                alpe_pkg::CFG_ZERO_LOW:  r_zero_low  <= i_cfg_data[alpe_pkg::LEN_W-1:0];
                alpe_pkg::CFG_GAP:       r_gap       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input item decode
    logic                              in_fire;
    logic                              in_act;
    logic [alpe_pkg::IDX_W-1:0]        in_idx;
    logic [alpe_pkg::WORD_W-1:0]       in_word;
    logic                              we;
    logic [alpe_pkg::PIX_W-1:0]        waddr;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign in_act  = s_axis_tuser[0];
    assign in_idx  = s_axis_tdata[alpe_pkg::IDX_W-1:0];
    assign in_word = s_axis_tdata[alpe_pkg::IDX_W +: alpe_pkg::WORD_W];
    assign waddr   = alpe_pkg::PIX_W'(in_idx);
    assign we      = in_fire && (in_act == alpe_pkg::ACT_WRITE)
                     && (32'(in_idx) < 32'(alpe_pkg::PIXEL_COUNT));

    // Frame state
    t_phase                            r_phase;
    logic [alpe_pkg::GAP_W-1:0]        r_tick;
    logic [alpe_pkg::BIT_W-1:0]        r_bitpos;
    logic [alpe_pkg::PIX_W-1:0]        r_pix;
    logic [alpe_pkg::WORD_W-1:0]       r_shift;

    // Pixel store with prefetch of the next pixel to load
    logic [alpe_pkg::PIX_W-1:0]        rd_addr;
    logic [alpe_pkg::WORD_W-1:0]       rdata;
    logic [alpe_pkg::PIXEL_COUNT-1:0]  r_valid;
    logic                              r_rdv;
    logic                              r_fwd_v;
    logic [alpe_pkg::WORD_W-1:0]       r_fwd_d;
    logic [alpe_pkg::WORD_W-1:0]       load_word;

    assign rd_addr = (r_phase == PH_LEAD || r_phase == PH_TRAIL || r_pix == alpe_pkg::LAST_PIX)
                     ? '0 : r_pix + 1'b1;

    alpe_ram #(
        .WIDTH (alpe_pkg::WORD_W),
        .DEPTH (alpe_pkg::PIXEL_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (in_word),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // Valid bits stand in for clearing; forward a write that hit the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rdv   <= 1'b0;
            r_fwd_v <= 1'b0;
        end else begin
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
            r_rdv   <= r_valid[rd_addr];
            r_fwd_v <= we && (waddr == rd_addr);
        end
        r_fwd_d <= in_word;
    end

    assign load_word = r_fwd_v ? r_fwd_d : (r_rdv ? rdata : '0);

    // Length of the current phase and its end
    logic                              cur_bit;
    logic [alpe_pkg::GAP_W-1:0]        raw_len;
    logic [alpe_pkg::GAP_W-1:0]        len;
    logic                              expire;
    logic                              level;

    assign cur_bit = r_shift[r_bitpos];
    assign level   = (r_phase == PH_HIGH);

    always_comb begin
        case (r_phase)
            PH_HIGH: raw_len = alpe_pkg::GAP_W'(cur_bit ? r_one_high : r_zero_high);
            PH_LOW:  raw_len = alpe_pkg::GAP_W'(cur_bit ? r_one_low : r_zero_low);
            default: raw_len = r_gap;
        endcase
        len    = (raw_len == '0) ? alpe_pkg::GAP_W'(1) : raw_len;
        expire = ({1'b0, r_tick} + 17'd1) >= {1'b0, len};
    end

    // Next state for a tick item
    t_phase                            n_phase;
    logic [alpe_pkg::GAP_W-1:0]        n_tick;
    logic [alpe_pkg::BIT_W-1:0]        n_bitpos;
    logic [alpe_pkg::PIX_W-1:0]        n_pix;
    logic [alpe_pkg::WORD_W-1:0]       n_shift;
    logic                              n_done;

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick + 1'b1;
        n_bitpos = r_bitpos;
        n_pix    = r_pix;
        n_shift  = r_shift;
        n_done   = 1'b0;
        if (expire) begin
            n_tick = '0;
            case (r_phase)
                PH_LEAD: begin
                    n_pix    = '0;
                    n_shift  = load_word;
                    n_bitpos = alpe_pkg::FIRST_BIT;
                    n_phase  = PH_HIGH;
                end
                PH_HIGH: begin
                    n_phase = PH_LOW;
                end
                PH_LOW: begin
                    if (r_bitpos != '0) begin
                        n_bitpos = r_bitpos - 1'b1;
                        n_phase  = PH_HIGH;
                    end else if (r_pix != alpe_pkg::LAST_PIX) begin
                        n_pix    = r_pix + 1'b1;
                        n_shift  = load_word;
                        n_bitpos = alpe_pkg::FIRST_BIT;
                        n_phase  = PH_HIGH;
                    end else begin
                        n_phase = PH_TRAIL;
                    end
                end
                default: begin
                    n_done  = 1'b1;
                    n_phase = PH_LEAD;
                end
            endcase
        end
    end

    // Frame state and output/skid registers
    logic       r_out_v, r_out_pin, r_out_done;
    logic       r_sk_v, r_sk_pin, r_sk_done;
    logic       out_fire;
    logic       res_done;

    assign out_fire      = r_out_v && m_axis_tready;
    assign s_axis_tready = i_rst_n && !r_sk_v;
    assign res_done      = (in_act == alpe_pkg::ACT_TICK) && n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEAD;
            r_tick   <= '0;
            r_bitpos <= alpe_pkg::FIRST_BIT;
            r_pix    <= '0;
            r_shift  <= '0;
            r_out_v  <= 1'b0;
            r_sk_v   <= 1'b0;
        end else begin
            if (in_fire && in_act == alpe_pkg::ACT_TICK) begin
                r_phase  <= n_phase;
                r_tick   <= n_tick;
                r_bitpos <= n_bitpos;
                r_pix    <= n_pix;
                r_shift  <= n_shift;
            end
            if (r_sk_v) begin
                if (out_fire) begin
                    r_out_pin  <= r_sk_pin;
                    r_out_done <= r_sk_done;
                    r_sk_v     <= 1'b0;
                end
            end else if (in_fire) begin
                if (!r_out_v || out_fire) begin
                    r_out_v    <= 1'b1;
                    r_out_pin  <= level;
                    r_out_done <= res_done;
                end else begin
                    r_sk_v    <= 1'b1;
                    r_sk_pin  <= level;
                    r_sk_done <= res_done;
                end
            end else if (out_fire) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {{(alpe_pkg::M_TDATA_W - 1){1'b0}}, r_out_pin};
    assign m_axis_tlast  = r_out_done;

endmodule

`default_nettype wire

### design/alpe_ram.sv
`default_nettype none

// Simple dual-port RAM, registered read, read returns the old data on a collision
module alpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### design/alpe_checker.sv
`default_nettype none

// Port-level checks for the pulse encoder
module alpe_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [alpe_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input wire logic                            m_axis_tlast
);

    // Input backpressure only when an item waits at the output
    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with output empty");

    // A stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output item changed");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // Frame end falls in the trailing gap, line low
    a_done_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[0])
        else $error("frame end with data line high");

endmodule

bind addressable_led_pulse_encoder_core alpe_checker u_alpe_checker (.*);

`default_nettype wire

### tb/addressable_led_pulse_encoder_core_tb.sv
`timescale 1ns / 1ps

module addressable_led_pulse_encoder_core_tb;
    import alpe_pkg::*;

    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_AFTER  = 200;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 8;
    localparam int REPORT_LIMIT    = 10;

    typedef enum logic [1:0] {GAP_LEAD, BIT_HIGH, BIT_LOW, GAP_TRAIL} wave_phase_e;
    typedef enum logic [1:0] {ROW_TICK, ROW_WRITE, ROW_CFG} row_kind_e;

    typedef struct packed {
        logic pin;
        logic done;
    } line_level_t;

    typedef struct {
        row_kind_e         kind;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] word;
        int                reps;
        bit                typed;
        line_level_t       level;
    } stim_row_t;

    typedef struct {
        logic [CFG_DATA_W-1:0] one_hi;
        logic [CFG_DATA_W-1:0] one_lo;
        logic [CFG_DATA_W-1:0] zero_hi;
        logic [CFG_DATA_W-1:0] zero_lo;
        logic [CFG_DATA_W-1:0] gap;
    } wave_setting_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;   // pixel_index, pixel_value
    logic [0:0]             s_axis_tuser = '0;   // action
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;        // data_pin
    logic                   m_axis_tlast;        // frame_done
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    addressable_led_pulse_encoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Waveform predictor state
    logic [WORD_W-1:0] led_words [PIXEL_COUNT];
    wave_phase_e       wave_phase;
    logic [GAP_W-1:0]  ticks_spent;
    logic [BIT_W-1:0]  bit_sel;
    logic [PIX_W-1:0]  pix_sel;
    logic [WORD_W-1:0] sending_word;
    logic [LEN_W-1:0]  one_hi_len, one_lo_len, zero_hi_len, zero_lo_len;
    logic [GAP_W-1:0]  gap_len;

    line_level_t levels_due [$];
    stim_row_t   dir_rows [$];
    int          mismatches = 0;
    int          send_quiet = 0;

    // Length of the current phase; a zero register counts as one tick
    function automatic int unsigned span_of_phase();
        int unsigned len;
        logic cur;
        cur = sending_word[bit_sel];
        case (wave_phase)
            BIT_HIGH: len = cur ? one_hi_len : zero_hi_len;
            BIT_LOW:  len = cur ? one_lo_len : zero_lo_len;
            default:  len = gap_len;
        endcase
        return (len == 0) ? 1 : len;
    endfunction

    // Word is captured when its first bit starts
    function automatic void latch_pixel();
        sending_word = led_words[pix_sel];
        bit_sel      = FIRST_BIT;
    endfunction

    function automatic line_level_t encoder_step(input logic act, input logic [IDX_W-1:0] idx,
                                                 input logic [WORD_W-1:0] word);
        line_level_t lv;
        lv.pin  = (wave_phase == BIT_HIGH);
        lv.done = 1'b0;
        // store write: no tick passes
        if (act == ACT_WRITE) begin
            if (int'(idx) < PIXEL_COUNT) led_words[idx] = word;
            return lv;
        end
        if (32'(ticks_spent) + 1 >= span_of_phase()) begin
            ticks_spent = '0;
            case (wave_phase)
                GAP_LEAD: begin
                    pix_sel = '0;
                    latch_pixel();
                    wave_phase = BIT_HIGH;
                end
                BIT_HIGH: wave_phase = BIT_LOW;
                BIT_LOW: begin
                    if (bit_sel != '0) begin
                        bit_sel    = bit_sel - 1'b1;
                        wave_phase = BIT_HIGH;
                    end else if (pix_sel != LAST_PIX) begin
                        pix_sel = pix_sel + 1'b1;
                        latch_pixel();
                        wave_phase = BIT_HIGH;
                    end else begin
                        wave_phase = GAP_TRAIL;
                    end
                end
                default: begin
                    lv.done    = 1'b1;
                    wave_phase = GAP_LEAD;
                end
            endcase
        end else begin
            ticks_spent = ticks_spent + 1'b1;
        end
        return lv;
    endfunction

    function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ONE_HIGH:  one_hi_len  = data[LEN_W-1:0];
            CFG_ONE_LOW:   one_lo_len  = data[LEN_W-1:0];
            CFG_ZERO_HIGH: zero_hi_len = data[LEN_W-1:0];
            CFG_ZERO_LOW:  zero_lo_len = data[LEN_W-1:0];
            CFG_GAP:       gap_len     = data[GAP_W-1:0];
            default: ;
        endcase
    endfunction

    // Mostly short gaps, a few long ones, now and then a run with none
    function automatic int pick_pause(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Length register word with junk above the 10 used bits
    function automatic logic [CFG_DATA_W-1:0] len_word(input logic [LEN_W-1:0] len);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        d[LEN_W-1:0] = len;
        return d;
    endfunction

    function automatic wave_setting_t quick_setting();
        wave_setting_t ws;
        ws.one_hi  = len_word(LEN_W'($urandom_range(0, 3)));
        ws.one_lo  = len_word(LEN_W'($urandom_range(0, 3)));
        ws.zero_hi = len_word(LEN_W'($urandom_range(0, 3)));
        ws.zero_lo = len_word(LEN_W'($urandom_range(0, 3)));
        ws.gap     = CFG_DATA_W'($urandom_range(0, 6));
        return ws;
    endfunction

    function automatic void add_row(input row_kind_e kind, input logic [IDX_W-1:0] idx,
                                    input logic [WORD_W-1:0] word, input int reps,
                                    input bit typed, input logic pin, input logic done);
        stim_row_t row;
        row.kind       = kind;
        row.idx        = idx;
        row.word       = word;
        row.reps       = reps;
        row.typed      = typed;
        row.level.pin  = pin;
        row.level.done = done;
        dir_rows.push_back(row);
    endfunction

    // Offer one item, keep valid up across back-to-back items
    task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
                             input logic [WORD_W-1:0] word, input bit typed,
                             input line_level_t typed_level);
        int pause;
        line_level_t lv;
        pause = pick_pause(send_quiet);
        if (pause > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= S_TDATA_W'({word, idx});
        do @(posedge i_clk); while (!s_axis_tready);
        lv = encoder_step(act, idx, word);
        levels_due.push_back(typed ? typed_level : lv);
    endtask

    // Register write once the stream has drained
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        s_axis_tvalid <= 1'b0;
        while (levels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_setting(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input wave_setting_t ws, input int items);
        logic [WORD_W-1:0] word;
        line_level_t none;
        none = '0;
        write_setting(CFG_ONE_HIGH, ws.one_hi);
        write_setting(CFG_ONE_LOW, ws.one_lo);
        write_setting(CFG_ZERO_HIGH, ws.zero_hi);
        write_setting(CFG_ZERO_LOW, ws.zero_lo);
        write_setting(CFG_GAP, ws.gap);
        // unmapped index, must be ignored
        write_setting(CFG_IDX_W'($urandom_range(CFG_GAP + 1, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
        repeat (items) begin
            if ($urandom_range(0, 99) < 12) begin
                word = $urandom;
                case ($urandom_range(0, 9))
                    0: word = '0;
                    1: word = '1;
                    default: ;
                endcase
                send_item(ACT_WRITE, IDX_W'($urandom_range(0, PIXEL_COUNT - 1)), word,
                          1'b0, none);
            end else begin
                send_item(ACT_TICK, IDX_W'($urandom), WORD_W'($urandom), 1'b0, none);
            end
        end
    endtask

    // Output side: check each item, pace tready
    int  results_seen = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    int  recv_quiet = 0;
    bit  held = 1'b0;

    always @(posedge i_clk) begin
        line_level_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (levels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected output item: tdata %h tlast %b",
                             m_axis_tdata, m_axis_tlast);
            end else begin
                want = levels_due.pop_front();
                if (m_axis_tdata !== M_TDATA_W'(want.pin) || m_axis_tlast !== want.done) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("output item %0d: tdata exp %h got %h, tlast exp %b got %b",
                                 results_seen, M_TDATA_W'(want.pin), m_axis_tdata,
                                 want.done, m_axis_tlast);
                end
            end
            results_seen++;
        end
        // one long hold-off so the input side backs up
        if (!held && results_seen >= HOLD_OFF_AFTER) begin
            held      = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            stall_left = pick_pause(recv_quiet);
            m_axis_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // Watchdog on cycles with no handshake at all
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wave_setting_t ws;
        // predictor at reset
        foreach (led_words[p]) led_words[p] = '0;
        wave_phase   = GAP_LEAD;
        ticks_spent  = '0;
        bit_sel      = FIRST_BIT;
        pix_sel      = '0;
        sending_word = '0;
        one_hi_len   = ONE_HIGH_RST;
        one_lo_len   = ONE_LOW_RST;
        zero_hi_len  = ZERO_HIGH_RST;
        zero_lo_len  = ZERO_LOW_RST;
        gap_len      = GAP_RST;

        // Directed: store extremes during the long leading gap, line stays low
        add_row(ROW_WRITE, 3'd0, 32'hFFFF_FFFF, 1, 1'b1, 1'b0, 1'b0);
        add_row(ROW_WRITE, 3'd7, 32'h0000_0000, 1, 1'b1, 1'b0, 1'b0);
        add_row(ROW_WRITE, 3'd1, 32'h8000_0001, 1, 1'b1, 1'b0, 1'b0);
        add_row(ROW_WRITE, 3'd2, 32'hAAAA_AAAA, 1, 1'b1, 1'b0, 1'b0);
        add_row(ROW_WRITE, 3'd3, 32'h5555_5555, 1, 1'b1, 1'b0, 1'b0);
        add_row(ROW_WRITE, 3'd4, 32'h0000_FFFF, 1, 1'b1, 1'b0, 1'b0);
        add_row(ROW_WRITE, 3'd5, 32'hFFFF_0000, 1, 1'b1, 1'b0, 1'b0);
        add_row(ROW_WRITE, 3'd6, 32'h1234_5678, 1, 1'b1, 1'b0, 1'b0);
        add_row(ROW_TICK,  3'd0, 32'h0,         4, 1'b1, 1'b0, 1'b0);
        // zero gap and zero high length act as one tick; upper junk is dropped
        add_row(ROW_CFG, CFG_GAP,       32'h0000, 1, 1'b0, 1'b0, 1'b0);
        add_row(ROW_CFG, CFG_ONE_HIGH,  32'hFC00, 1, 1'b0, 1'b0, 1'b0);
        add_row(ROW_CFG, CFG_ONE_LOW,   32'h0002, 1, 1'b0, 1'b0, 1'b0);
        add_row(ROW_CFG, CFG_ZERO_HIGH, 32'h0001, 1, 1'b0, 1'b0, 1'b0);
        add_row(ROW_CFG, CFG_ZERO_LOW,  32'hFC02, 1, 1'b0, 1'b0, 1'b0);
        add_row(ROW_TICK, 3'd0, 32'h0, 12, 1'b0, 1'b0, 1'b0);
        // overwrite the pixel on the line: takes effect next frame
        add_row(ROW_WRITE, 3'd0, 32'h0000_0000, 1, 1'b0, 1'b0, 1'b0);
        add_row(ROW_TICK, 3'd0, 32'h0, 10, 1'b0, 1'b0, 1'b0);
        // stretch the low time part way through a bit
        add_row(ROW_CFG, CFG_ONE_LOW, 32'h0005, 1, 1'b0, 1'b0, 1'b0);
        add_row(ROW_TICK, 3'd0, 32'h0, 8, 1'b0, 1'b0, 1'b0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            case (dir_rows[r].kind)
                ROW_CFG: write_setting(dir_rows[r].idx, dir_rows[r].word[CFG_DATA_W-1:0]);
                default: begin
                    repeat (dir_rows[r].reps)
                        send_item((dir_rows[r].kind == ROW_WRITE) ? ACT_WRITE : ACT_TICK,
                                  dir_rows[r].idx, dir_rows[r].word, dir_rows[r].typed,
                                  dir_rows[r].level);
                end
            endcase
        end

        // fastest timing: whole frames and the trailing gap flag
        ws.one_hi  = len_word('0);
        ws.one_lo  = len_word('0);
        ws.zero_hi = len_word('0);
        ws.zero_lo = len_word('0);
        ws.gap     = '0;
        run_phase(ws, 800);
        run_phase(quick_setting(), 60);

        // longest lengths
        ws.one_hi  = len_word('1);
        ws.one_lo  = len_word('1);
        ws.zero_hi = len_word('1);
        ws.zero_lo = len_word('1);
        ws.gap     = '1;
        run_phase(ws, 30);
        run_phase(quick_setting(), 60);

        // back to power-on timing
        ws.one_hi  = CFG_DATA_W'(ONE_HIGH_RST);
        ws.one_lo  = CFG_DATA_W'(ONE_LOW_RST);
        ws.zero_hi = CFG_DATA_W'(ZERO_HIGH_RST);
        ws.zero_lo = CFG_DATA_W'(ZERO_LOW_RST);
        ws.gap     = CFG_DATA_W'(GAP_RST);
        run_phase(ws, 30);

        s_axis_tvalid <= 1'b0;
        while (levels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
